@@ sv/clard_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers of the cursor list block.
// Used by clard_dp, clard_ctrl and cursor_list_append_reverse_dump.
package clard_pkg;

  // Pool size and derived widths
  localparam int CAPACITY = 16;
  localparam int CELL_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic [LINK_W-1:0] NULL_IDX = LINK_W'(CAPACITY);

  // Command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUMPED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch_in;    // capture the input beat's value
    logic       alloc;       // pop free chain, store value, start tail walk
    logic       walk_step;   // one step of the tail walk
    logic       dwalk_start; // load list head for a dump walk
    logic       dwalk_step;  // push one list cell on the stack
    logic       rd_issue;    // read value of the stack top cell
    logic       out_load;    // load the result register
    logic       out_dump;    // result carries RAM data, pops the stack
    logic [1:0] out_status;
    logic       out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic free_is_cell;
    logic head_is_cell;
    logic walk_done;
    logic dwalk_done;
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } dp_sts_t;

  // A link outside the pool counts as null
  function automatic logic is_cell(input logic [LINK_W-1:0] idx);
    return idx < LINK_W'(CAPACITY);
  endfunction

endpackage

@@ sv/clard_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module clard_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/clard_dp.sv @@
`timescale 1ns / 1ps
// Datapath: link table, free/list heads, dump stack, value RAM and result register.
// Depends on clard_pkg and clard_ram.
module clard_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  clard_pkg::dp_cmd_t              cmd,
  output clard_pkg::dp_sts_t              sts,
  input  logic signed [clard_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic signed [clard_pkg::VAL_W-1:0] out_element,
  output logic                            out_last
);

  localparam int CAPACITY = clard_pkg::CAPACITY;
  localparam int CELL_W   = clard_pkg::CELL_W;
  localparam int LINK_W   = clard_pkg::LINK_W;
  localparam int CNT_W    = clard_pkg::CNT_W;
  localparam int VAL_W    = clard_pkg::VAL_W;

  logic [LINK_W-1:0] links_r [CAPACITY];
  logic [LINK_W-1:0] free_head_r;
  logic [LINK_W-1:0] list_head_r;
  logic [CELL_W-1:0] cell_r;
  logic [CELL_W-1:0] trav_r;
  logic [LINK_W-1:0] idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CELL_W-1:0] stack_r [CAPACITY];
  logic [VAL_W-1:0]  value_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [VAL_W-1:0]  out_element_r;
  logic              out_last_r;

  logic [CELL_W-1:0] lr_addr;
  logic [LINK_W-1:0] lr_data;
  logic              lw_en;
  logic [CELL_W-1:0] lw_addr;
  logic [LINK_W-1:0] lw_data;
  logic              nxt_is_cell;
  logic              walk_last;
  logic [CNT_W-1:0]  cnt_m1;
  logic [VAL_W-1:0]  ram_rdata;
  logic              dwalk_push;

  // Link table read address follows the active walk
  always_comb begin
    lr_addr = trav_r;
    if (cmd.alloc) begin
      lr_addr = free_head_r[CELL_W-1:0];
    end else if (cmd.dwalk_step) begin
      lr_addr = idx_r[CELL_W-1:0];
    end
  end

  assign lr_data     = links_r[lr_addr];
  assign nxt_is_cell = clard_pkg::is_cell(lr_data);
  assign walk_last   = (cnt_r == CNT_W'(CAPACITY - 1));
  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign dwalk_push  = cmd.dwalk_step && !sts.dwalk_done;

  // Link table write: new cell gets null, tail gets the new cell
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cell_r;
    lw_data = clard_pkg::NULL_IDX;
    if (cmd.alloc) begin
      lw_en   = 1'b1;
      lw_addr = free_head_r[CELL_W-1:0];
    end else if (cmd.walk_step && sts.walk_done) begin
      lw_en   = 1'b1;
      lw_addr = nxt_is_cell ? lr_data[CELL_W-1:0] : trav_r;
      lw_data = LINK_W'(cell_r);
    end
  end

  // Status back to the controller
  always_comb begin
    sts.free_is_cell = clard_pkg::is_cell(free_head_r);
    sts.head_is_cell = clard_pkg::is_cell(list_head_r);
    sts.walk_done    = !nxt_is_cell || walk_last;
    sts.dwalk_done   = !clard_pkg::is_cell(idx_r) || (cnt_r == CNT_W'(CAPACITY));
    sts.cnt_zero     = (cnt_r == '0);
    sts.cnt_one      = (cnt_r == CNT_W'(1));
    sts.out_free     = !out_valid_r || out_ready;
  end

  // Control state of the pool: links and heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        links_r[i] <= LINK_W'(i + 1);
      end
      free_head_r <= '0;
      list_head_r <= clard_pkg::NULL_IDX;
    end else begin
      if (lw_en) begin
        links_r[lw_addr] <= lw_data;
      end
      if (cmd.alloc) begin
        free_head_r <= lr_data;
        if (!sts.head_is_cell) begin
          list_head_r <= free_head_r;
        end
      end
    end
  end

  // Walk registers, dump stack and input capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      value_r <= in_value;
    end
    if (cmd.alloc) begin
      cell_r <= free_head_r[CELL_W-1:0];
      trav_r <= list_head_r[CELL_W-1:0];
      cnt_r  <= '0;
    end
    if (cmd.walk_step && !sts.walk_done) begin
      trav_r <= lr_data[CELL_W-1:0];
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (cmd.dwalk_start) begin
      idx_r <= list_head_r;
      cnt_r <= '0;
    end
    if (dwalk_push) begin
      stack_r[cnt_r[CELL_W-1:0]] <= idx_r[CELL_W-1:0];
      idx_r <= lr_data;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.out_load && cmd.out_dump) begin
      cnt_r <= cnt_m1;
    end
  end

  // Cell values
  clard_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_values (
    .clk  (clk),
    .we   (cmd.alloc),
    .waddr(free_head_r[CELL_W-1:0]),
    .wdata(value_r),
    .re   (cmd.rd_issue),
    .raddr(stack_r[cnt_m1[CELL_W-1:0]]),
    .rdata(ram_rdata)
  );

  // Result register: load when free, drop valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r  <= cmd.out_status;
      out_element_r <= cmd.out_dump ? ram_rdata : '0;
      out_last_r    <= cmd.out_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

@@ sv/clard_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences append walks and reverse dumps over the datapath.
// Depends on clard_pkg.
module clard_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  output clard_pkg::dp_cmd_t cmd,
  input  clard_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_RESULT,
    S_DWALK,
    S_DREAD,
    S_DEMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] res_r, res_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state, result code and datapath commands
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          if (in_command == clard_pkg::CMD_APPEND) begin
            if (sts.free_is_cell) begin
              state_nxt = S_ALLOC;
            end else begin
              res_nxt   = clard_pkg::ST_FULL;
              state_nxt = S_RESULT;
            end
          end else begin
            cmd.dwalk_start = 1'b1;
            state_nxt       = S_DWALK;
          end
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        res_nxt   = clard_pkg::ST_APPENDED;
        state_nxt = sts.head_is_cell ? S_WALK : S_RESULT;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DWALK: begin
        cmd.dwalk_step = 1'b1;
        if (sts.dwalk_done) begin
          if (sts.cnt_zero) begin
            res_nxt   = clard_pkg::ST_EMPTY;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_DREAD;
          end
        end
      end
      S_DREAD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DEMIT;
      end
      S_DEMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_dump   = 1'b1;
          cmd.out_status = clard_pkg::ST_DUMPED;
          cmd.out_last   = sts.cnt_one;
          state_nxt      = sts.cnt_one ? S_IDLE : S_DREAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and pending result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= clard_pkg::ST_APPENDED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

@@ sv/cursor_list_append_reverse_dump.sv @@
`timescale 1ns / 1ps
// Top level of the cursor list: a pool of CAPACITY cells with append and reverse dump.
// Depends on clard_pkg, clard_ctrl and clard_dp.
//
// One item is worked at a time. An append to an empty list goes from allocation straight
// to the result; otherwise the tail of the list (up to CAPACITY cells long) is found first
// by following one link per cycle through the single read port of the link table. A rejected
// append (pool full) goes straight to the result. A dump walks the list one link per cycle to
// fill a stack, then reads each stacked value from the value RAM and emits it, one element
// at a time, waiting while the result register is held; an empty list gives a single result.
// The result register frees the output side: a stalled result only delays the next load.
module cursor_list_append_reverse_dump (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [clard_pkg::VAL_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [clard_pkg::VAL_W-1:0] out_element,
  output logic                               out_last
);

  clard_pkg::dp_cmd_t cmd;
  clard_pkg::dp_sts_t sts;

  // Sequencer
  clard_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Storage and result register
  clard_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_element(out_element),
    .out_last   (out_last)
  );

endmodule
